// ----- rtl/pdq_pkg.sv -----
package pdq_pkg;

	// Sizes of the queue table and the shared slot buffer.
	localparam int unsigned QUEUES = 16;
	localparam int unsigned SLOTS  = 256;

	localparam int unsigned QIDX_W = $clog2(QUEUES);
	localparam int unsigned SLOT_W = $clog2(SLOTS);
	localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

	localparam int unsigned ID_W     = 16;
	localparam int unsigned HANDLE_W = 16;

	// Configuration port geometry: three 32-bit registers at 0x0, 0x4, 0x8.
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef logic [ID_W-1:0]     id_t;
	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [QIDX_W-1:0]   qidx_t;
	typedef logic [SLOT_W-1:0]   slot_idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic [1:0] {
		REG_UNSET  = 2'd0,
		REG_BCAST  = 2'd1,
		REG_BEACON = 2'd2
	} reg_idx_t;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_DEQ  = 1'b1
	} action_t;

	typedef enum logic [3:0] {
		ST_NEW_P2P = 4'd0,
		ST_P2P     = 4'd1,
		ST_BCAST   = 4'd2,
		ST_BEACON  = 4'd3,
		ST_DEQ     = 4'd4,
		ST_UNSET   = 4'd5,
		ST_NOQ     = 4'd6,
		ST_EMPTY   = 4'd7,
		ST_FULL    = 4'd8
	} status_t;

	typedef struct packed {
		logic    action;
		id_t     dest_id;
		handle_t packet_handle;
	} in_item_t;

	typedef struct packed {
		status_t status;
		handle_t handle_out;
	} out_item_t;

	typedef struct packed {
		id_t unset_id;
		id_t broadcast_id;
		id_t beacon_id;
	} cfg_t;

	// One entry of the queue pointer memory.
	typedef struct packed {
		slot_idx_t head;
		slot_idx_t tail;
		cnt_t      count;
	} qent_t;

	// One entry of the slot memory.
	typedef struct packed {
		handle_t   handle;
		slot_idx_t next;
	} slot_t;

	typedef struct packed {
		logic  hit;
		qidx_t hit_idx;
		logic  has_free;
		qidx_t free_idx;
	} qt_look_t;

	typedef struct packed {
		qidx_t rd_idx;
		logic  wr_en;
		qidx_t wr_idx;
		qent_t wr_data;
		logic  open_en;
		qidx_t open_idx;
	} qt_cmd_t;

	typedef struct packed {
		slot_idx_t rd_addr;
		slot_idx_t wr_addr;
		logic      we_handle;
		logic      we_next;
		handle_t   wr_handle;
		slot_idx_t wr_next;
	} sl_cmd_t;

endpackage

// ----- rtl/per_destination_packet_queues.sv -----
// Per-destination packet queues: one FIFO of 16-bit packet handles per
// destination ID, all sharing one buffer of slots linked as lists.
// The request channel (req, req_valid, req_ready) carries one transfer per
// push or dequeue. The response channel (rsp, rsp_valid, rsp_ready) returns
// exactly one transfer per request, in order, with a status code and, for a
// successful dequeue, the head handle of the named queue.
// The block works on one request at a time. After a request transfer it
// goes from S_LOOK through the states the request needs to S_RESP, which
// loads the response register and returns to S_IDLE to take the next one.
// A refused push or a dequeue from an unknown link goes straight to S_RESP;
// a push into a new or empty queue passes S_PUSH, a push onto a non-empty
// queue also S_LINK, which links the new slot behind the old tail, a dequeue
// from an empty queue S_DEQ_R and a successful dequeue S_DEQ_R and S_DEQ_W.
// The extra states come from the registered reads of the queue pointer and
// slot memories, whose entries are read and written back in different cycles.
// The response sits in an output register, so a stalled receiver does not
// stop the next request from being processed; only a second finished
// response waits until rsp_ready frees the register.
// Reset (arst_n low) closes every queue, marks every slot free and restores
// the special IDs; requests are taken from the first cycle after reset.
module per_destination_packet_queues (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pdq_pkg::ADDR_W-1:0]    paddr,
	input  logic [pdq_pkg::DATA_W-1:0]    pwdata,
	output logic [pdq_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  pdq_pkg::in_item_t             req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output pdq_pkg::out_item_t            rsp
);

	// The APB port holds unset_id, broadcast_id and beacon_id at 0x0, 0x4, 0x8.
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOOK  = 7'b0000010,
		S_PUSH  = 7'b0000100,
		S_LINK  = 7'b0001000,
		S_DEQ_R = 7'b0010000,
		S_DEQ_W = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t                 state_q, state_d;
	pdq_pkg::cfg_t          cfg;
	pdq_pkg::qt_look_t      look;
	pdq_pkg::qt_cmd_t       qt_cmd;
	pdq_pkg::qent_t         q_rd;
	pdq_pkg::sl_cmd_t       sl_cmd;
	pdq_pkg::slot_t         sl_rd;

	// Request and working registers.
	pdq_pkg::in_item_t      item_q;
	pdq_pkg::qidx_t         q_idx_q;
	logic                   opened_q;
	pdq_pkg::status_t       status_q;
	pdq_pkg::handle_t       handle_q;
	pdq_pkg::slot_idx_t     link_tail_q, link_slot_q;
	pdq_pkg::qent_t         qent_q;

	// Free slot bookkeeping. Slots that were never used are handed out by
	// the fresh counter; returned slots form a list linked through the
	// slot memory, with its head in free_head_q.
	pdq_pkg::cnt_t          fresh_q, free_cnt_q;
	pdq_pkg::slot_idx_t     free_head_q;

	pdq_pkg::out_item_t     rsp_q;
	logic                   rsp_valid_q;

	logic                   is_unset, no_room, buf_empty, use_fresh;
	pdq_pkg::status_t       push_status;
	pdq_pkg::slot_idx_t     new_slot;
	pdq_pkg::cnt_t          push_cnt;

	pdq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pdq_qtable u_qtable (
		.clk    (clk),
		.arst_n (arst_n),
		.dest   (item_q.dest_id),
		.cmd    (qt_cmd),
		.look   (look),
		.rdata  (q_rd)
	);

	pdq_slots u_slots (
		.clk   (clk),
		.cmd   (sl_cmd),
		.rdata (sl_rd)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Push classification; the unset check wins over everything else and
	// broadcast is tested before beacon.
	assign is_unset  = (item_q.dest_id == cfg.unset_id);
	assign no_room   = !look.hit && !look.has_free;
	assign buf_empty = (free_cnt_q == '0);
	assign use_fresh = (fresh_q < pdq_pkg::CNT_W'(pdq_pkg::SLOTS));
	assign new_slot  = use_fresh ? fresh_q[pdq_pkg::SLOT_W-1:0] : free_head_q;
	// A freshly opened queue reads stale pointers, so its count is forced.
	assign push_cnt  = opened_q ? '0 : q_rd.count;

	always_comb begin
		if (item_q.dest_id == cfg.broadcast_id) begin
			push_status = pdq_pkg::ST_BCAST;
		end else if (item_q.dest_id == cfg.beacon_id) begin
			push_status = pdq_pkg::ST_BEACON;
		end else if (!look.hit) begin
			push_status = pdq_pkg::ST_NEW_P2P;
		end else begin
			push_status = pdq_pkg::ST_P2P;
		end
	end

	always_comb begin
		state_d        = state_q;
		qt_cmd         = '0;
		qt_cmd.rd_idx  = look.hit ? look.hit_idx : look.free_idx;
		sl_cmd         = '0;
		sl_cmd.rd_addr = free_head_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (item_q.action == pdq_pkg::ACT_PUSH) begin
					state_d = (is_unset || no_room || buf_empty) ? S_RESP : S_PUSH;
				end else begin
					state_d = look.hit ? S_DEQ_R : S_RESP;
				end
			end
			S_PUSH: begin
				qt_cmd.wr_en         = 1'b1;
				qt_cmd.wr_idx        = q_idx_q;
				qt_cmd.wr_data.head  = (push_cnt == '0) ? new_slot : q_rd.head;
				qt_cmd.wr_data.tail  = new_slot;
				qt_cmd.wr_data.count = push_cnt + pdq_pkg::CNT_W'(1);
				qt_cmd.open_en       = opened_q;
				qt_cmd.open_idx      = q_idx_q;
				sl_cmd.we_handle     = 1'b1;
				sl_cmd.wr_addr       = new_slot;
				sl_cmd.wr_handle     = item_q.packet_handle;
				state_d = (push_cnt == '0) ? S_RESP : S_LINK;
			end
			S_LINK: begin
				sl_cmd.we_next = 1'b1;
				sl_cmd.wr_addr = link_tail_q;
				sl_cmd.wr_next = link_slot_q;
				state_d        = S_RESP;
			end
			S_DEQ_R: begin
				sl_cmd.rd_addr = q_rd.head;
				state_d = (q_rd.count == '0) ? S_RESP : S_DEQ_W;
			end
			S_DEQ_W: begin
				qt_cmd.wr_en         = 1'b1;
				qt_cmd.wr_idx        = q_idx_q;
				qt_cmd.wr_data.head  = sl_rd.next;
				qt_cmd.wr_data.tail  = qent_q.tail;
				qt_cmd.wr_data.count = qent_q.count - pdq_pkg::CNT_W'(1);
				// The dequeued slot goes on top of the free list.
				sl_cmd.we_next = 1'b1;
				sl_cmd.wr_addr = qent_q.head;
				sl_cmd.wr_next = free_head_q;
				state_d        = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fresh_q     <= '0;
			free_cnt_q  <= pdq_pkg::CNT_W'(pdq_pkg::SLOTS);
			free_head_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_PUSH) begin
				free_cnt_q <= free_cnt_q - pdq_pkg::CNT_W'(1);
				if (use_fresh) begin
					fresh_q <= fresh_q + pdq_pkg::CNT_W'(1);
				end else begin
					free_head_q <= sl_rd.next;
				end
			end
			if (state_q == S_DEQ_W) begin
				free_head_q <= qent_q.head;
				if (free_cnt_q < pdq_pkg::CNT_W'(pdq_pkg::SLOTS)) begin
					free_cnt_q <= free_cnt_q + pdq_pkg::CNT_W'(1);
				end
			end
			if (state_q == S_RESP && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					item_q <= req;
				end
			end
			S_LOOK: begin
				handle_q <= '0;
				q_idx_q  <= qt_cmd.rd_idx;
				opened_q <= !look.hit;
				if (item_q.action == pdq_pkg::ACT_PUSH) begin
					if (is_unset) begin
						status_q <= pdq_pkg::ST_UNSET;
					end else if (no_room || buf_empty) begin
						status_q <= pdq_pkg::ST_FULL;
					end else begin
						status_q <= push_status;
					end
				end else begin
					status_q <= pdq_pkg::ST_NOQ;
				end
			end
			S_PUSH: begin
				link_tail_q <= q_rd.tail;
				link_slot_q <= new_slot;
			end
			S_DEQ_R: begin
				qent_q   <= q_rd;
				status_q <= (q_rd.count == '0) ? pdq_pkg::ST_EMPTY : pdq_pkg::ST_DEQ;
			end
			S_DEQ_W: begin
				handle_q <= sl_rd.handle;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_q.status     <= status_q;
					rsp_q.handle_out <= handle_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/pdq_cfg.sv -----
module pdq_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pdq_pkg::ADDR_W-1:0]    paddr,
	input  logic [pdq_pkg::DATA_W-1:0]    pwdata,
	output logic [pdq_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output pdq_pkg::cfg_t                 cfg
);

	pdq_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unset_id     <= 16'hFFFF;
			cfg_q.broadcast_id <= 16'hFFFE;
			cfg_q.beacon_id    <= 16'hFFFD;
		end else if (wr_en) begin
			unique case (paddr[pdq_pkg::ADDR_W-1:2])
				pdq_pkg::REG_UNSET: begin
					cfg_q.unset_id <= pwdata[pdq_pkg::ID_W-1:0];
				end
				pdq_pkg::REG_BCAST: begin
					cfg_q.broadcast_id <= pwdata[pdq_pkg::ID_W-1:0];
				end
				pdq_pkg::REG_BEACON: begin
					cfg_q.beacon_id <= pwdata[pdq_pkg::ID_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[pdq_pkg::ADDR_W-1:2])
			pdq_pkg::REG_UNSET: begin
				prdata = pdq_pkg::DATA_W'(cfg_q.unset_id);
			end
			pdq_pkg::REG_BCAST: begin
				prdata = pdq_pkg::DATA_W'(cfg_q.broadcast_id);
			end
			pdq_pkg::REG_BEACON: begin
				prdata = pdq_pkg::DATA_W'(cfg_q.beacon_id);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

// ----- rtl/pdq_qtable.sv -----
module pdq_qtable (
	input  logic              clk,
	input  logic              arst_n,
	input  pdq_pkg::id_t      dest,
	input  pdq_pkg::qt_cmd_t  cmd,
	output pdq_pkg::qt_look_t look,
	output pdq_pkg::qent_t    rdata
);

	// Destination tags and their valid bits are flops so that all of them
	// can be compared at once; the pointers live in a one-port-read memory.
	pdq_pkg::id_t                  ids_q [pdq_pkg::QUEUES];
	logic [pdq_pkg::QUEUES-1:0]    valid_q;
	pdq_pkg::qent_t                mem_q [pdq_pkg::QUEUES];
	pdq_pkg::qent_t                rdata_q;

	assign rdata = rdata_q;

	// Scanning from the top down leaves the lowest matching index.
	always_comb begin
		look = '0;
		for (int i = int'(pdq_pkg::QUEUES) - 1; i >= 0; i--) begin
			if (valid_q[i] && ids_q[i] == dest) begin
				look.hit     = 1'b1;
				look.hit_idx = pdq_pkg::QIDX_W'(i);
			end
			if (!valid_q[i]) begin
				look.has_free = 1'b1;
				look.free_idx = pdq_pkg::QIDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.open_en) begin
			valid_q[cmd.open_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.open_en) begin
			ids_q[cmd.open_idx] <= dest;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[cmd.wr_idx] <= cmd.wr_data;
		end
		rdata_q <= mem_q[cmd.rd_idx];
	end

endmodule

// ----- rtl/pdq_slots.sv -----
module pdq_slots (
	input  logic             clk,
	input  pdq_pkg::sl_cmd_t cmd,
	output pdq_pkg::slot_t   rdata
);

	// Slot memory with a per-field write mask: handle and link pointer are
	// written in separate cycles.
	pdq_pkg::slot_t mem_q [pdq_pkg::SLOTS];
	pdq_pkg::slot_t rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.we_handle) begin
			mem_q[cmd.wr_addr].handle <= cmd.wr_handle;
		end
		if (cmd.we_next) begin
			mem_q[cmd.wr_addr].next <= cmd.wr_next;
		end
		rdata_q <= mem_q[cmd.rd_addr];
	end

endmodule

// ----- tb/per_destination_packet_queues_tb.sv -----
`timescale 1ns / 1ps

module per_destination_packet_queues_tb;

	// Phase sizes. The receiver's one long hold-off starts once LONG_HOLD_AT responses
	// have arrived, which lands inside the buffer-filling phase (directed part plus three
	// mixed phases come to roughly 560 requests), so the block backs up while the sender
	// keeps offering pushes.
	localparam int MIX_LEN      = 180;
	localparam int FILL_LEN     = 300;
	localparam int LONG_HOLD_AT = 640;
	localparam int LONG_HOLD    = 400;
	localparam int CYCLE_LIMIT  = 400000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      psel      = 1'b0;
	logic      penable   = 1'b0;
	logic      pwrite    = 1'b0;
	logic [pdq_pkg::ADDR_W-1:0] paddr  = '0;
	logic [pdq_pkg::DATA_W-1:0] pwdata = '0;
	logic [pdq_pkg::DATA_W-1:0] prdata;
	logic      pready;
	logic      req_valid = 1'b0;
	logic      req_ready;
	pdq_pkg::in_item_t  req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	pdq_pkg::out_item_t rsp;

	per_destination_packet_queues dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #2 clk = ~clk;

	// Requests waiting to be offered, and the responses owed for requests already taken.
	pdq_pkg::in_item_t  req_backlog[$];
	pdq_pkg::out_item_t due_replies[$];

	// When calm is set, neither side inserts idle cycles.
	bit          calm = 1'b0;
	int          failures = 0;
	int          accepted_n = 0;
	int          status_tally[9];
	int unsigned cycle_n = 0;

	// Shadow of the block: special IDs, the queue table, the slot buffer and the free stack.
	pdq_pkg::id_t     cfg_unset  = 16'hFFFF;
	pdq_pkg::id_t     cfg_bcast  = 16'hFFFE;
	pdq_pkg::id_t     cfg_beacon = 16'hFFFD;
	bit               q_open[pdq_pkg::QUEUES];
	pdq_pkg::id_t     q_id[pdq_pkg::QUEUES];
	int               q_head[pdq_pkg::QUEUES];
	int               q_tail[pdq_pkg::QUEUES];
	int               q_cnt[pdq_pkg::QUEUES];
	pdq_pkg::handle_t sl_handle[pdq_pkg::SLOTS];
	int               sl_next[pdq_pkg::SLOTS];
	int               free_stk[pdq_pkg::SLOTS];
	int               free_n;

	// Applies one request to the shadow state and returns the response it must produce.
	function automatic pdq_pkg::out_item_t serve_request(pdq_pkg::in_item_t it);
		pdq_pkg::out_item_t r;
		int        q;
		int        slot;
		bit        opened;
		r.status     = pdq_pkg::ST_NEW_P2P;
		r.handle_out = '0;
		q = -1;
		opened = 1'b0;
		for (int i = 0; i < pdq_pkg::QUEUES; i++)
			if (q < 0 && q_open[i] && q_id[i] == it.dest_id)
				q = i;
		if (it.action == pdq_pkg::ACT_PUSH) begin
			if (it.dest_id == cfg_unset) begin
				r.status = pdq_pkg::ST_UNSET;
			end else begin
				if (q < 0) begin
					for (int i = 0; i < pdq_pkg::QUEUES; i++)
						if (q < 0 && !q_open[i])
							q = i;
					opened = (q >= 0);
				end
				// A full table or a full buffer refuses the push and opens nothing.
				if (q < 0 || free_n == 0) begin
					r.status = pdq_pkg::ST_FULL;
				end else begin
					free_n--;
					slot = free_stk[free_n];
					sl_handle[slot] = it.packet_handle;
					if (opened) begin
						q_open[q] = 1'b1;
						q_id[q]   = it.dest_id;
						q_cnt[q]  = 0;
					end
					if (q_cnt[q] == 0)
						q_head[q] = slot;
					else
						sl_next[q_tail[q]] = slot;
					q_tail[q] = slot;
					q_cnt[q]++;
					// Broadcast wins over beacon when both IDs are the same.
					if (it.dest_id == cfg_bcast)
						r.status = pdq_pkg::ST_BCAST;
					else if (it.dest_id == cfg_beacon)
						r.status = pdq_pkg::ST_BEACON;
					else
						r.status = opened ? pdq_pkg::ST_NEW_P2P : pdq_pkg::ST_P2P;
				end
			end
		end else if (q < 0) begin
			r.status = pdq_pkg::ST_NOQ;
		end else if (q_cnt[q] == 0) begin
			r.status = pdq_pkg::ST_EMPTY;
		end else begin
			slot = q_head[q];
			r.handle_out = sl_handle[slot];
			r.status     = pdq_pkg::ST_DEQ;
			q_head[q] = sl_next[slot];
			q_cnt[q]--;
			free_stk[free_n] = slot;
			free_n++;
		end
		return r;
	endfunction

	// Idle length: mostly none, sometimes a few cycles, now and then a long gap.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_req(pdq_pkg::action_t a, pdq_pkg::id_t d,
		pdq_pkg::handle_t h);
		pdq_pkg::in_item_t it;
		it.action        = a;
		it.dest_id       = d;
		it.packet_handle = h;
		req_backlog.push_back(it);
	endfunction

	// Request driver. Once an item is offered it stays put until the transfer happens;
	// after each transfer the driver may idle for a random number of cycles.
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			gap_left  <= 0;
		end else begin
			if (req_valid && req_ready) begin
				pdq_pkg::out_item_t r;
				r = serve_request(req);
				status_tally[r.status]++;
				due_replies.push_back(r);
				accepted_n++;
			end
			if (!req_valid || req_ready) begin
				if (gap_left > 0) begin
					req_valid <= 1'b0;
					gap_left  <= gap_left - 1;
				end else if (req_backlog.size() != 0) begin
					req       <= req_backlog.pop_front();
					req_valid <= 1'b1;
					gap_left  <= idle_len();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor. Every transfer is checked against the oldest owed response.
	// rsp_ready drops at random, and once for a long stretch so the block fills up.
	int rsp_n = 0;
	int stall_left = 0;
	bit held_long = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				pdq_pkg::out_item_t want;
				rsp_n <= rsp_n + 1;
				if (due_replies.size() == 0) begin
					$error("response with nothing outstanding: status %0d handle_out %0h",
						rsp.status, rsp.handle_out);
					failures++;
				end else begin
					want = due_replies.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						failures++;
					end
					if (rsp.handle_out !== want.handle_out) begin
						$error("handle_out: expected %0h, actual %0h",
							want.handle_out, rsp.handle_out);
						failures++;
					end
				end
			end
			if (!held_long && rsp_n >= LONG_HOLD_AT) begin
				rsp_ready  <= 1'b0;
				stall_left <= LONG_HOLD;
				held_long  <= 1'b1;
			end else if (stall_left > 0) begin
				rsp_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_ready  <= 1'b0;
				stall_left <= idle_len();
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n == CYCLE_LIMIT) begin
			$display("per_destination_packet_queues_tb NOT OK");
			$finish;
		end
	end

	// One APB write: setup cycle, then the access cycle in which the register updates.
	// The shadow copy follows once the write has landed.
	task automatic reg_write(pdq_pkg::reg_idx_t idx, pdq_pkg::id_t val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			pdq_pkg::REG_UNSET:  cfg_unset  = val;
			pdq_pkg::REG_BCAST:  cfg_bcast  = val;
			pdq_pkg::REG_BEACON: cfg_beacon = val;
			default: ;
		endcase
	endtask

	// The sender holds back until every request has been answered.
	task automatic wait_idle();
		while (req_backlog.size() != 0 || req_valid || due_replies.size() != 0)
			@(posedge clk);
	endtask

	pdq_pkg::id_t dest_pool[16];

	initial begin
		pdq_pkg::id_t     live[$];
		int               drain[$];
		pdq_pkg::id_t     d;
		pdq_pkg::id_t     v;
		pdq_pkg::action_t a;
		int               r;
		int               k;

		// Shadow reset: every queue closed, every slot on the free stack.
		for (int i = 0; i < pdq_pkg::QUEUES; i++)
			q_open[i] = 1'b0;
		for (int i = 0; i < pdq_pkg::SLOTS; i++)
			free_stk[i] = i;
		free_n = pdq_pkg::SLOTS;

		// The destination pool holds the extremes, the default special IDs and twelve
		// distinct mid-range IDs; together they exactly fill the queue table.
		dest_pool[0] = 16'h0000;
		dest_pool[1] = 16'hFFFF;
		dest_pool[2] = 16'hFFFE;
		dest_pool[3] = 16'hFFFD;
		for (int i = 4; i < 16; i++)
			dest_pool[i] = pdq_pkg::id_t'((i - 3) * 256 + $urandom_range(0, 255));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Write every register with its reset value first.
		reg_write(pdq_pkg::REG_UNSET, 16'hFFFF);
		reg_write(pdq_pkg::REG_BCAST, 16'hFFFE);
		reg_write(pdq_pkg::REG_BEACON, 16'hFFFD);

		// Directed part with the default special IDs: refused push to the unset ID,
		// unknown links (the unset ID among them), new and existing queues, broadcast
		// and beacon queues, dequeues down to an empty queue.
		add_req(pdq_pkg::ACT_PUSH, 16'hFFFF, 16'h1234);
		add_req(pdq_pkg::ACT_DEQ,  16'hFFFF, 16'h0000);
		add_req(pdq_pkg::ACT_DEQ,  16'h0000, 16'hFFFF);
		add_req(pdq_pkg::ACT_PUSH, 16'h0000, 16'hFFFF);
		add_req(pdq_pkg::ACT_PUSH, 16'h0000, 16'h0000);
		add_req(pdq_pkg::ACT_PUSH, 16'hFFFE, 16'hAAAA);
		add_req(pdq_pkg::ACT_PUSH, 16'hFFFE, 16'h5555);
		add_req(pdq_pkg::ACT_PUSH, 16'hFFFD, 16'h0001);
		add_req(pdq_pkg::ACT_DEQ,  16'h0000, 16'h0000);
		add_req(pdq_pkg::ACT_DEQ,  16'h0000, 16'h0000);
		add_req(pdq_pkg::ACT_DEQ,  16'h0000, 16'h0000);
		add_req(pdq_pkg::ACT_DEQ,  16'hFFFE, 16'h0000);
		add_req(pdq_pkg::ACT_DEQ,  16'hFFFD, 16'h0000);
		add_req(pdq_pkg::ACT_DEQ,  16'hFFFD, 16'h0000);
		add_req(pdq_pkg::ACT_PUSH, 16'hFFFD, 16'h8000);
		wait_idle();

		// Broadcast and beacon share one ID, and the unset ID names an open queue.
		reg_write(pdq_pkg::REG_UNSET, 16'h0000);
		reg_write(pdq_pkg::REG_BCAST, 16'hFFFF);
		reg_write(pdq_pkg::REG_BEACON, 16'hFFFF);
		add_req(pdq_pkg::ACT_PUSH, 16'hFFFF, 16'h7FFF);
		add_req(pdq_pkg::ACT_PUSH, 16'h0000, 16'h0F0F);
		add_req(pdq_pkg::ACT_DEQ,  16'h0000, 16'h0000);
		add_req(pdq_pkg::ACT_DEQ,  16'hFFFF, 16'h0000);
		add_req(pdq_pkg::ACT_PUSH, 16'hFFFE, 16'hF0F0);
		add_req(pdq_pkg::ACT_DEQ,  16'hFFFE, 16'h0000);
		add_req(pdq_pkg::ACT_DEQ,  16'hFFFE, 16'h0000);
		wait_idle();

		// Six mixed phases, with the buffer filled to overflow and drained again between
		// the third and the fourth. In the first phases random IDs get only dequeues, so the table
		// fills with queues that see traffic; later phases also push to random IDs,
		// which the full table refuses.
		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			calm = (ph == 2 || ph == 4);
			if (ph == 0) begin
				reg_write(pdq_pkg::REG_UNSET, 16'h8000);
				reg_write(pdq_pkg::REG_BCAST, dest_pool[4]);
				reg_write(pdq_pkg::REG_BEACON, dest_pool[5]);
			end else begin
				for (k = 0; k < 3; k++) begin
					r = $urandom_range(0, 3);
					if (r == 0)
						v = 16'h0000;
					else if (r == 1)
						v = 16'hFFFF;
					else if (r == 2)
						v = dest_pool[$urandom_range(0, 15)];
					else
						v = pdq_pkg::id_t'($urandom);
					reg_write(pdq_pkg::reg_idx_t'(k), v);
				end
			end

			if (ph == 3) begin
				// Fill the shared buffer past its capacity with pushes to open queues,
				// then drain every queue in random order down to one empty dequeue each.
				live.delete();
				for (int i = 0; i < pdq_pkg::QUEUES; i++)
					if (q_open[i] && q_id[i] != cfg_unset)
						live.push_back(q_id[i]);
				for (int n = 0; n < FILL_LEN && live.size() != 0; n++)
					add_req(pdq_pkg::ACT_PUSH, live[$urandom_range(0, live.size() - 1)],
						pdq_pkg::handle_t'($urandom));
				wait_idle();
				drain.delete();
				for (int i = 0; i < pdq_pkg::QUEUES; i++)
					if (q_open[i])
						for (int n = 0; n <= q_cnt[i]; n++)
							drain.push_back(i);
				while (drain.size() != 0) begin
					r = $urandom_range(0, drain.size() - 1);
					add_req(pdq_pkg::ACT_DEQ, q_id[drain[r]], pdq_pkg::handle_t'($urandom));
					drain.delete(r);
				end
				wait_idle();
			end

			for (int n = 0; n < MIX_LEN; n++) begin
				r = $urandom_range(0, 99);
				a = ($urandom_range(0, 99) < 52) ? pdq_pkg::ACT_PUSH : pdq_pkg::ACT_DEQ;
				if (r < 80) begin
					d = dest_pool[$urandom_range(0, 15)];
				end else if (r < 88) begin
					d = pdq_pkg::id_t'($urandom);
					if (ph < 3)
						a = pdq_pkg::ACT_DEQ;
				end else if (r < 92) begin
					d = cfg_unset;
				end else if (r < 96) begin
					d = cfg_bcast;
				end else begin
					d = cfg_beacon;
				end
				add_req(a, d, pdq_pkg::handle_t'($urandom));
			end
		end

		wait_idle();
		calm = 1'b0;
		repeat (20) @(posedge clk);

		$display("Run covered %0d requests over several special-ID settings, %s",
			accepted_n, "with the table and the buffer driven full.");
		$display("Outcomes: new %0d, p2p %0d, bcast %0d, beacon %0d, deq %0d, %s %0d, %s %0d",
			status_tally[pdq_pkg::ST_NEW_P2P], status_tally[pdq_pkg::ST_P2P],
			status_tally[pdq_pkg::ST_BCAST], status_tally[pdq_pkg::ST_BEACON],
			status_tally[pdq_pkg::ST_DEQ], "unset", status_tally[pdq_pkg::ST_UNSET],
			"noq", status_tally[pdq_pkg::ST_NOQ]);
		$display("Outcomes: empty %0d, full %0d",
			status_tally[pdq_pkg::ST_EMPTY], status_tally[pdq_pkg::ST_FULL]);
		if (failures == 0)
			$display("per_destination_packet_queues_tb OK");
		else
			$display("per_destination_packet_queues_tb NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/pdq_pkg.sv
rtl/pdq_cfg.sv
rtl/pdq_qtable.sv
rtl/pdq_slots.sv
rtl/per_destination_packet_queues.sv
tb/per_destination_packet_queues_tb.sv
